// ----- rtl/core/running_median_distance_filter_core_macros.svh -----
// assertion macros for the running median distance filter core
`ifndef RUNNING_MEDIAN_DISTANCE_FILTER_CORE_MACROS_SVH
`define RUNNING_MEDIAN_DISTANCE_FILTER_CORE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define RMDF_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("rmdf check failed");

// consequent must hold in the cycle after the antecedent
`define RMDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmdf check failed");

`endif

// ----- rtl/core/rmdf_pkg.sv -----
// shared types and constants of the running median distance filter
`default_nettype none
package rmdf_pkg;

  localparam int MAX_WINDOW_DEF = 16;
  localparam int DIST_W         = 16;
  localparam int STATUS_W       = 4;
  localparam int LEN_W          = 5;

  localparam logic [LEN_W-1:0]    WLEN_RESET     = 5'd3;
  localparam logic [STATUS_W-1:0] STATUS_OK      = 4'd0;
  localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_MERGE,
    ST_WRITE
  } seq_state_t;

  // merge bookkeeping handed to the compare unit
  typedef struct packed {
    logic have_x;
    logic drop_pend;
    logic ins_pend;
  } merge_ctl_t;

  // decision returned by the compare unit
  typedef struct packed {
    logic drop_hit;
    logic take_new;
    logic emit;
    logic consume;
    logic done;
  } merge_dec_t;

endpackage
`default_nettype wire

// ----- rtl/core/rmdf_ram.sv -----
// generic single write, single read ram with registered read data
`default_nettype none
module rmdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/rmdf_merge_unit.sv -----
// compare unit for one step of the sorted list rebuild
`default_nettype none
module rmdf_merge_unit (
  input  wire logic [rmdf_pkg::DIST_W-1:0] x,
  input  wire logic [rmdf_pkg::DIST_W-1:0] v,
  input  wire logic [rmdf_pkg::DIST_W-1:0] d,
  input  wire rmdf_pkg::merge_ctl_t        ctl,
  output rmdf_pkg::merge_dec_t             dec,
  output logic      [rmdf_pkg::DIST_W-1:0] emit_data
);

  always_comb begin
    // skip one copy of the value that leaves the window
    dec.drop_hit = ctl.have_x && ctl.drop_pend && (x == d);
    // new value goes in before the first element not below it
    dec.take_new = !dec.drop_hit && ctl.ins_pend && (!ctl.have_x || (v <= x));
    dec.emit     = !dec.drop_hit && (dec.take_new || ctl.have_x);
    dec.consume  = dec.drop_hit || (ctl.have_x && !dec.take_new);
    dec.done     = !ctl.have_x && !ctl.ins_pend;
    emit_data    = dec.take_new ? v : x;
  end

endmodule
`default_nettype wire

// ----- rtl/core/running_median_distance_filter_core.sv -----
// top level of the running median distance filter: sequencer, window store, output register
//
//  channel | ports                     | fields, lowest bit up
//  --------+---------------------------+------------------------------------------------
//  in      | in_tvalid/in_tready/tdata | reading_present, sensor_code, distance_mm
//  out     | out_tvalid/tready/tdata   | result_status, previous_status, latest_distance,
//          |                           | median_distance, window_nonempty, window_count
//  cfg     | cfg_we/cfg_wdata          | window_length
//
//  a valid reading passes from accept through the prime state, merge steps of the shared
//  compare unit and the write-out state; an invalid reading goes from accept straight to
//  write-out; in_tready is high only while the sequencer is idle, so a new reading is
//  accepted only after the previous one has left write-out
//  a held result waits in the output register; the next transaction is accepted meanwhile
//  and its write-out waits for the register to free
//  synchronous active-low reset, no clearing pass: only entries below the count are read
`default_nettype none
module running_median_distance_filter_core #(
  parameter int MAX_WINDOW = rmdf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: reading_present[0], sensor_code[4:1], distance_mm[20:5], zero pad
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,
  // out_tdata: result_status[3:0], previous_status[7:4], latest_distance[23:8],
  // median_distance[39:24], window_nonempty[40], window_count[45:41], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata
);

  localparam int DW = rmdf_pkg::DIST_W;
  localparam int SW = rmdf_pkg::STATUS_W;
  localparam int CW = $clog2(MAX_WINDOW + 1);          // count, 0..MAX_WINDOW
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW = (CW > rmdf_pkg::LEN_W) ? CW : rmdf_pkg::LEN_W;
  localparam int OW = CW + 1;                           // ring offset arithmetic
  localparam int SDEPTH = 2 * (2 ** AW);                // two banks of sorted list

  // input fields
  logic          in_present;
  logic [SW-1:0] in_code;
  logic [DW-1:0] in_dist;
  assign in_present = in_tdata[0];
  assign in_code    = in_tdata[4:1];
  assign in_dist    = in_tdata[20:5];

  // sequencer and window state
  rmdf_pkg::seq_state_t state_r, state_nxt;
  logic [rmdf_pkg::LEN_W-1:0] cfg_len_r;
  logic [CW-1:0] cnt_r, cnt_nxt;          // samples held
  logic [CW-1:0] cnt_new_r, cnt_new_nxt;  // count after this transaction
  logic [CW-1:0] ptr_r, ptr_nxt;          // sorted element on read data
  logic [CW-1:0] ocnt_r, ocnt_nxt;        // sorted elements written out
  logic [AW-1:0] wp_r, wp_nxt;            // ring slot for the next sample
  logic          bank_r, bank_nxt;
  logic          ins_pend_r, ins_pend_nxt;
  logic          drop_pend_r, drop_pend_nxt;
  logic [DW-1:0] v_r, v_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [DW-1:0] latest_r, latest_nxt;
  logic [DW-1:0] median_r, median_nxt;
  logic [DW-1:0] med_new_r, med_new_nxt;
  logic [SW-1:0] status_r, status_nxt;
  logic [SW-1:0] prev_r, prev_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic [47:0]   out_data_r, out_data_nxt;

  logic in_acc, out_free, invalid;
  logic [LW-1:0] len_ext, len_eff;
  logic          drop_now;
  logic [OW-1:0] old_off;
  logic [AW-1:0] old_addr;

  // ram ports
  logic          ring_we;
  logic [DW-1:0] ring_rdata;
  logic [AW:0]   s_raddr, s_waddr;
  logic          s_we;
  logic [DW-1:0] s_rdata;

  // compare unit
  rmdf_pkg::merge_ctl_t ctl;
  rmdf_pkg::merge_dec_t dec;
  logic [DW-1:0]        emit_data;

  assign in_tready  = (state_r == rmdf_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  assign invalid = !in_present || (in_code != rmdf_pkg::STATUS_OK) || (in_dist == '0);

  // window length clamped to 1..MAX_WINDOW
  assign len_ext = LW'(cfg_len_r);
  always_comb begin
    if (len_ext == '0) begin
      len_eff = LW'(1);
    end else if (len_ext > LW'(MAX_WINDOW)) begin
      len_eff = LW'(MAX_WINDOW);
    end else begin
      len_eff = len_ext;
    end
  end
  // a full window drops its single oldest sample
  assign drop_now = (LW'(cnt_r) >= len_eff);

  // oldest sample sits count slots behind the write pointer
  always_comb begin
    old_off = OW'(wp_r) + OW'(MAX_WINDOW) - OW'(cnt_r);
    if (old_off >= OW'(MAX_WINDOW)) begin
      old_off = old_off - OW'(MAX_WINDOW);
    end
    old_addr = old_off[AW-1:0];
  end

  assign ctl.have_x    = (ptr_r < cnt_r);
  assign ctl.drop_pend = drop_pend_r;
  assign ctl.ins_pend  = ins_pend_r;

  rmdf_merge_unit u_merge (
    .x         (s_rdata),
    .v         (v_r),
    .d         (d_r),
    .ctl       (ctl),
    .dec       (dec),
    .emit_data (emit_data)
  );

  // ring of samples in arrival order, read once per transaction for the leaving value
  rmdf_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp_r),
    .wdata (v_r),
    .raddr (old_addr),
    .rdata (ring_rdata)
  );

  // sorted list, rebuilt from one bank into the other on each valid reading
  rmdf_ram #(
    .WIDTH (DW),
    .DEPTH (SDEPTH)
  ) u_sorted (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (emit_data),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rmdf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = invalid ? rmdf_pkg::ST_WRITE : rmdf_pkg::ST_PRIME;
        end
      end
      rmdf_pkg::ST_PRIME: begin
        state_nxt = rmdf_pkg::ST_MERGE;
      end
      rmdf_pkg::ST_MERGE: begin
        if (dec.done) begin
          state_nxt = rmdf_pkg::ST_WRITE;
        end
      end
      rmdf_pkg::ST_WRITE: begin
        if (out_free) begin
          state_nxt = rmdf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rmdf_pkg::ST_IDLE;
    endcase
  end

  // datapath and ram controls
  always_comb begin
    cnt_nxt       = cnt_r;
    cnt_new_nxt   = cnt_new_r;
    ptr_nxt       = ptr_r;
    ocnt_nxt      = ocnt_r;
    wp_nxt        = wp_r;
    bank_nxt      = bank_r;
    ins_pend_nxt  = ins_pend_r;
    drop_pend_nxt = drop_pend_r;
    v_nxt         = v_r;
    d_nxt         = d_r;
    latest_nxt    = latest_r;
    median_nxt    = median_r;
    med_new_nxt   = med_new_r;
    status_nxt    = status_r;
    prev_nxt      = prev_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_data_nxt  = out_data_r;
    ring_we       = 1'b0;
    s_we          = 1'b0;
    s_waddr       = {!bank_r, ocnt_r[AW-1:0]};
    s_raddr       = {bank_r, {AW{1'b0}}};

    case (state_r)
      rmdf_pkg::ST_IDLE: begin
        if (in_acc) begin
          prev_nxt      = status_r;
          status_nxt    = (invalid && (in_code == rmdf_pkg::STATUS_OK)) ?
                          rmdf_pkg::STATUS_TIMEOUT : in_code;
          med_new_nxt   = median_r;
          ptr_nxt       = '0;
          ocnt_nxt      = '0;
          v_nxt         = in_dist;
          ins_pend_nxt  = !invalid;
          drop_pend_nxt = !invalid && drop_now;
          if (invalid) begin
            cnt_new_nxt = '0;
          end else begin
            latest_nxt  = in_dist;
            cnt_new_nxt = drop_now ? cnt_r : cnt_r + CW'(1);
          end
        end
      end
      rmdf_pkg::ST_PRIME: begin
        // ring read happened at accept; now the new sample takes its slot
        d_nxt   = ring_rdata;
        ring_we = 1'b1;
        wp_nxt  = (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + AW'(1);
      end
      rmdf_pkg::ST_MERGE: begin
        if (dec.consume) begin
          ptr_nxt = ptr_r + CW'(1);
        end
        if (dec.drop_hit) begin
          drop_pend_nxt = 1'b0;
        end
        if (dec.take_new) begin
          ins_pend_nxt = 1'b0;
        end
        if (dec.emit) begin
          s_we     = 1'b1;
          ocnt_nxt = ocnt_r + CW'(1);
          if (ocnt_r == (cnt_new_r >> 1)) begin
            med_new_nxt = emit_data;
          end
        end
        s_raddr = {bank_r, (ptr_nxt < cnt_r) ? ptr_nxt[AW-1:0] : {AW{1'b0}}};
      end
      rmdf_pkg::ST_WRITE: begin
        if (out_free) begin
          cnt_nxt      = cnt_new_r;
          median_nxt   = med_new_r;
          bank_nxt     = !bank_r;
          out_vld_nxt  = 1'b1;
          out_data_nxt = {2'b00, 5'(cnt_new_r), (cnt_new_r != '0),
                          med_new_r, latest_r, prev_r, status_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rmdf_pkg::ST_IDLE;
      cfg_len_r <= rmdf_pkg::WLEN_RESET;
      cnt_r     <= '0;
      wp_r      <= '0;
      bank_r    <= 1'b0;
      latest_r  <= '0;
      median_r  <= '0;
      status_r  <= rmdf_pkg::STATUS_OK;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_we) begin
        cfg_len_r <= cfg_wdata;
      end
      cnt_r     <= cnt_nxt;
      wp_r      <= wp_nxt;
      bank_r    <= bank_nxt;
      latest_r  <= latest_nxt;
      median_r  <= median_nxt;
      status_r  <= status_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // per-transaction working registers, no reset needed
  always_ff @(posedge clk) begin
    cnt_new_r   <= cnt_new_nxt;
    ptr_r       <= ptr_nxt;
    ocnt_r      <= ocnt_nxt;
    ins_pend_r  <= ins_pend_nxt;
    drop_pend_r <= drop_pend_nxt;
    v_r         <= v_nxt;
    d_r         <= d_nxt;
    med_new_r   <= med_new_nxt;
    prev_r      <= prev_nxt;
    out_data_r  <= out_data_nxt;
  end

`include "running_median_distance_filter_core_macros.svh"

  // the window never holds more than its storage
  `RMDF_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(MAX_WINDOW))
  // an invalid reading goes straight to write-out
  `RMDF_ASSERT_NEXT(a_invalid_short, in_acc && invalid, state_r == rmdf_pkg::ST_WRITE)
  // the rebuilt list never runs past the new count
  `RMDF_ASSERT_ALWAYS(a_merge_bound,
    (state_r != rmdf_pkg::ST_MERGE) || (ocnt_r <= cnt_new_r && ptr_r <= cnt_r))
  // the leaving value is always found before the pass ends
  `RMDF_ASSERT_NEXT(a_drop_found,
    state_r == rmdf_pkg::ST_MERGE && dec.done, !drop_pend_r)

endmodule
`default_nettype wire

// ----- tb/running_median_distance_filter_core_tb.sv -----
// self-checking testbench for the running median distance filter core
`timescale 1ns / 100ps
module running_median_distance_filter_core_tb;
  import rmdf_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_GAP       = 18;
  localparam int NUM_PHASES    = 9;
  localparam int NOISY_ITEMS   = 33;
  localparam int CLEAN_ITEMS   = 17;
  localparam int NUM_DIRECTED  = 20;

  // one filter result, packed as on out_tdata (first field highest)
  typedef struct packed {
    logic [LEN_W-1:0]    count;
    logic                nonempty;
    logic [DIST_W-1:0]   median;
    logic [DIST_W-1:0]   latest;
    logic [STATUS_W-1:0] prev_status;
    logic [STATUS_W-1:0] status;
  } filter_result_t;

  typedef struct {
    logic                present;
    logic [STATUS_W-1:0] code;
    logic [DIST_W-1:0]   dist_mm;
    bit                  typed;
    filter_result_t      res;
  } reading_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [4:0]  cfg_wdata  = '0;

  // predictor state
  logic [DIST_W-1:0]   win_samples [0:MAX_WINDOW_DEF];
  int                  held_samples;
  logic [DIST_W-1:0]   pred_latest;
  logic [DIST_W-1:0]   last_median;
  logic [STATUS_W-1:0] last_status;
  logic [LEN_W-1:0]    window_len;

  filter_result_t pending_results[$];
  int             mismatch_count;
  int             cycle_count;
  bit             quiet_run;
  bit             long_hold_req;
  reading_row_t   directed_rows [0:NUM_DIRECTED-1];

  running_median_distance_filter_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // advances the predicted filter by one reading
  function automatic filter_result_t filter_reading(logic present, logic [STATUS_W-1:0] code,
                                                    logic [DIST_W-1:0] dist_mm);
    filter_result_t      r;
    logic [STATUS_W-1:0] prev;
    logic [DIST_W-1:0]   sorted [0:MAX_WINDOW_DEF];
    logic [DIST_W-1:0]   v;
    int                  lim;
    int                  i;
    int                  j;
    prev        = last_status;
    last_status = code;
    if (!present || code != STATUS_OK || dist_mm == '0) begin
      held_samples = 0;
      if (code == STATUS_OK) last_status = STATUS_TIMEOUT;
    end else begin
      pred_latest = dist_mm;
      for (i = held_samples; i > 0; i--) win_samples[i] = win_samples[i-1];
      win_samples[0] = dist_mm;
      held_samples++;
      lim = (window_len < 1) ? 1 : (window_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : window_len;
      // only one oldest entry goes per reading, even after the length was lowered
      if (held_samples > lim) held_samples--;
      for (i = 0; i < held_samples; i++) begin
        v = win_samples[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      last_median = sorted[held_samples / 2];
    end
    r.status      = last_status;
    r.prev_status = prev;
    r.latest      = pred_latest;
    r.median      = last_median;
    r.nonempty    = (held_samples != 0);
    r.count       = held_samples[LEN_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // offers one reading, waits for the transaction, then records its expected result
  task automatic send_reading(logic present, logic [STATUS_W-1:0] code,
                              logic [DIST_W-1:0] dist_mm,
                              bit typed, filter_result_t typed_res);
    int             gap;
    filter_result_t predicted;
    gap = quiet_run ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {3'b000, dist_mm, code, present};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = filter_reading(present, code, dist_mm);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // mostly well-formed readings; noise items clear the window in various ways
  task automatic send_random(bit well_formed);
    logic                present;
    logic [STATUS_W-1:0] code;
    logic [DIST_W-1:0]   dist_mm;
    int                  pick;
    pick    = $urandom_range(0, 99);
    present = 1'b1;
    code    = STATUS_OK;
    dist_mm = $urandom_range(0, 1) ? DIST_W'($urandom_range(1, 65535))
                                   : DIST_W'($urandom_range(1, 24));
    if (!well_formed && pick < 18) begin
      case (pick % 3)
        0: begin
          present = 1'b0;
          code    = STATUS_W'($urandom_range(0, 15));
          dist_mm = DIST_W'($urandom_range(0, 65535));
        end
        1: code = STATUS_W'($urandom_range(1, 15));
        default: dist_mm = '0;
      endcase
    end
    send_reading(present, code, dist_mm, 1'b0, '0);
  endtask

  // writes the window length once the block has drained
  task automatic write_window_len(logic [LEN_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    window_len  = value;
  endtask

  // result checker: every transaction on the output is matched with the oldest expectation
  always @(posedge clk) begin : check_results
    filter_result_t got;
    filter_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = filter_result_t'(out_tdata[45:0]);
      if (pending_results.size() == 0) begin
        $error("result with no reading outstanding: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_status", want.status, got.status);
        check_field("previous_status", want.prev_status, got.prev_status);
        check_field("latest_distance", want.latest, got.latest);
        check_field("median_distance", want.median, got.median);
        check_field("window_nonempty", want.nonempty, got.nonempty);
        check_field("window_count", want.count, got.count);
      end
    end
  end

  // receiver: random stalls per transaction, one long hold-off on request
  initial begin : result_sink
    int waits;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_req) begin
        waits         = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        waits = quiet_run ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (waits != 0) begin
        out_tready <= 1'b0;
        repeat (waits) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [LEN_W-1:0] phase_lengths [0:NUM_PHASES-1];
    int               p;
    int               k;
    // zero and above-maximum lengths, and a drop from full window to two
    phase_lengths = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd5, 5'd17, 5'd8, 5'd3};
    // fields: present, code, distance, typed, {count, nonempty, median, latest, prev, status}
    directed_rows = '{
      '{1'b0, STATUS_OK, 16'd0, 1'b1, '{5'd0, 1'b0, 16'd0, 16'd0, STATUS_OK, STATUS_TIMEOUT}},
      '{1'b1, STATUS_OK, 16'd65535, 1'b1,
        '{5'd1, 1'b1, 16'd65535, 16'd65535, STATUS_TIMEOUT, STATUS_OK}},
      '{1'b1, STATUS_OK, 16'd1, 1'b1, '{5'd2, 1'b1, 16'd65535, 16'd1, STATUS_OK, STATUS_OK}},
      '{1'b1, STATUS_OK, 16'd100, 1'b1, '{5'd3, 1'b1, 16'd100, 16'd100, STATUS_OK, STATUS_OK}},
      '{1'b1, STATUS_OK, 16'd50, 1'b1, '{5'd3, 1'b1, 16'd50, 16'd50, STATUS_OK, STATUS_OK}},
      // present but zero distance: no target, timeout substituted
      '{1'b1, STATUS_OK, 16'd0, 1'b1, '{5'd0, 1'b0, 16'd50, 16'd50, STATUS_OK, STATUS_TIMEOUT}},
      '{1'b1, 4'd15, 16'd65535, 1'b1, '{5'd0, 1'b0, 16'd50, 16'd50, STATUS_TIMEOUT, 4'd15}},
      '{1'b0, 4'd15, 16'd65535, 1'b1, '{5'd0, 1'b0, 16'd50, 16'd50, 4'd15, 4'd15}},
      '{1'b0, STATUS_OK, 16'd1234, 1'b1, '{5'd0, 1'b0, 16'd50, 16'd50, 4'd15, STATUS_TIMEOUT}},
      '{1'b1, STATUS_TIMEOUT, 16'd7, 1'b1,
        '{5'd0, 1'b0, 16'd50, 16'd50, STATUS_TIMEOUT, STATUS_TIMEOUT}},
      '{1'b1, STATUS_OK, 16'd7, 1'b1, '{5'd1, 1'b1, 16'd7, 16'd7, STATUS_TIMEOUT, STATUS_OK}},
      '{1'b1, STATUS_OK, 16'd7, 1'b0, '0},
      '{1'b1, STATUS_OK, 16'd3, 1'b0, '0},
      '{1'b1, STATUS_OK, 16'd65535, 1'b0, '0},
      '{1'b1, STATUS_OK, 16'd2, 1'b0, '0},
      '{1'b1, 4'd8, 16'h5555, 1'b0, '0},
      '{1'b1, STATUS_OK, 16'hAAAA, 1'b0, '0},
      '{1'b1, STATUS_OK, 16'h5555, 1'b0, '0},
      '{1'b1, 4'd2, 16'd1, 1'b0, '0},
      '{1'b1, STATUS_OK, 16'd1, 1'b0, '0}
    };
    held_samples   = 0;
    pred_latest    = '0;
    last_median    = '0;
    last_status    = STATUS_OK;
    window_len     = WLEN_RESET;
    mismatch_count = 0;
    cycle_count    = 0;
    quiet_run      = 1'b0;
    long_hold_req  = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < NUM_DIRECTED; k++) begin
      send_reading(directed_rows[k].present, directed_rows[k].code, directed_rows[k].dist_mm,
                   directed_rows[k].typed, directed_rows[k].res);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      write_window_len(phase_lengths[p]);
      // back-to-back phases; in one of them the sink holds off so the input stalls
      quiet_run = (p == 1) || (p == 2) || (p == 5);
      if (p == 2) long_hold_req = 1'b1;
      for (k = 0; k < NOISY_ITEMS; k++) send_random(1'b0);
      // finish with a full window so the next length change meets a full store
      for (k = 0; k < CLEAN_ITEMS; k++) send_random(1'b1);
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/rmdf_pkg.sv
rtl/core/rmdf_ram.sv
rtl/core/rmdf_merge_unit.sv
rtl/core/running_median_distance_filter_core.sv
tb/running_median_distance_filter_core_tb.sv
